[src/sfd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Divider package
// Shared widths, status codes and the queue entry type of the signed divider.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int DATA_WIDTH_DEF = 64;
  localparam int FIELD_W = 64;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  // Classified item handed from the front end to the divide pipeline.
  typedef struct packed {
    logic [FIELD_W-1:0] mag_a;
    logic [FIELD_W-1:0] mag_b;
    logic [FIELD_W-1:0] b;
    logic sa;
    logic sb;
    logic floor_mode;
    logic rem_only;
    logic special;
    logic [FIELD_W-1:0] sp_q;
    logic [STATUS_W-1:0] sp_st;
  } item_t;

endpackage
`default_nettype wire

[src/sfd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Divider front end
// Sign-extends operands, takes magnitudes and flags the special divisors.
// ----------------------------------------------------------------------------
module sfd_front #(
  parameter int DATA_WIDTH = sfd_pkg::DATA_WIDTH_DEF
) (
  input  wire logic [sfd_pkg::FIELD_W-1:0] dividend,
  input  wire logic [sfd_pkg::FIELD_W-1:0] divisor,
  input  wire logic                        func,
  input  wire logic                        remainder_only,
  output sfd_pkg::item_t                   item
);
  localparam int W = sfd_pkg::FIELD_W;
  logic [W-1:0] a, b, minval;

  // Sign-extend the low DATA_WIDTH bits of each operand.
  always_comb begin
    a = {{(W-DATA_WIDTH){dividend[DATA_WIDTH-1]}}, dividend[DATA_WIDTH-1:0]};
    b = {{(W-DATA_WIDTH){divisor[DATA_WIDTH-1]}}, divisor[DATA_WIDTH-1:0]};
    minval = {{(W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
  end

  // Classify the item; zero and minus one divisors get their result here, not from the divide.
  always_comb begin
    item.sa = a[W-1];
    item.sb = b[W-1];
    item.mag_a = a[W-1] ? (~a + 1'b1) : a;
    item.mag_b = b[W-1] ? (~b + 1'b1) : b;
    item.b = b;
    item.floor_mode = func;
    item.rem_only = remainder_only;
    item.special = 1'b0;
    item.sp_q = '0;
    item.sp_st = sfd_pkg::ST_OK;
    if (b == '0) begin
      item.special = 1'b1;
      item.sp_st = sfd_pkg::ST_DIV_ZERO;
    end else if (b == '1) begin
      item.special = 1'b1;
      if (!remainder_only) begin
        if (a == minval) begin
          item.sp_st = sfd_pkg::ST_OVERFLOW;
        end else begin
          item.sp_q = ~a + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[src/sfd_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Decoupling queue
// Two-entry register queue between the front end and the divide pipeline.
// ----------------------------------------------------------------------------
module sfd_fifo (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_valid,
  output logic            wr_ready,
  input  wire sfd_pkg::item_t wr_data,
  output logic            rd_valid,
  input  wire logic       rd_ready,
  output sfd_pkg::item_t  rd_data
);
  sfd_pkg::item_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue overfilled");
  a_empty_no_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !do_rd) else $error("read from empty queue");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + 2'd1)) else $error("fill count slip");
endmodule
`default_nettype wire

[src/sfd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Divide pipeline
// Restoring divider, one quotient bit per stage, then sign and floor fixup.
// ----------------------------------------------------------------------------
module sfd_back #(
  parameter int DATA_WIDTH = sfd_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire sfd_pkg::item_t               in_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [sfd_pkg::FIELD_W-1:0]       q_o,
  output logic [sfd_pkg::FIELD_W-1:0]       r_o,
  output logic [sfd_pkg::STATUS_W-1:0]      st_o
);
  localparam int W = sfd_pkg::FIELD_W;
  localparam int N = DATA_WIDTH;
  localparam int S = N + 1;

  logic adv;
  logic vld_r [S+1];
  sfd_pkg::item_t it_r [S];
  logic [N-1:0] rem_r [S];
  logic [N-1:0] quo_r [S];
  logic [N-1:0] dvd_r [S];
  logic [W-1:0] q_r, r_r;
  logic [sfd_pkg::STATUS_W-1:0] st_r;
  logic [W-1:0] q_fix, r_fix;
  logic [N-1:0] qm, rm;

  // The whole pipeline moves together; it stalls only when its last result waits.
  assign adv = !vld_r[S] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[S];
  assign q_o = q_r;
  assign r_o = r_r;
  assign st_o = st_r;

  // Stage zero loads the operands.
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (adv) vld_r[0] <= in_valid;
    if (adv) begin
      it_r[0] <= in_item;
      rem_r[0] <= '0;
      quo_r[0] <= '0;
      dvd_r[0] <= in_item.mag_a[N-1:0];
    end
  end

  // One restoring step per stage, most significant dividend bit first.
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [N:0] trial;
    logic [N:0] sub;
    assign trial = {rem_r[k], dvd_r[k][N-1]};
    assign sub = trial - {1'b0, it_r[k].mag_b[N-1:0]};
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k+1] <= 1'b0;
      else if (adv) vld_r[k+1] <= vld_r[k];
      if (adv) begin
        it_r[k+1] <= it_r[k];
        dvd_r[k+1] <= {dvd_r[k][N-2:0], 1'b0};
        if (!sub[N]) begin
          rem_r[k+1] <= sub[N-1:0];
          quo_r[k+1] <= {quo_r[k][N-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= trial[N-1:0];
          quo_r[k+1] <= {quo_r[k][N-2:0], 1'b0};
        end
      end
    end
  end

  // Sign and floor correction on the raw magnitudes.
  always_comb begin
    sfd_pkg::item_t it;
    it = it_r[N];
    qm = quo_r[N];
    rm = rem_r[N];
    q_fix = {{(W-N){1'b0}}, qm};
    r_fix = {{(W-N){1'b0}}, rm};
    if (it.sa != it.sb) q_fix = ~q_fix + 1'b1;
    if (it.sa) r_fix = ~r_fix + 1'b1;
    if (it.floor_mode && (rm != '0) && (it.sa != it.sb)) begin
      q_fix = q_fix - 1'b1;
      r_fix = r_fix + it.b;
    end
    if (it.rem_only) q_fix = '0;
    if (it.special) begin
      q_fix = it.sp_q;
      r_fix = '0;
    end
  end

  // Output register, sign-extended from the operand width.
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[S] <= 1'b0;
    else if (adv) vld_r[S] <= vld_r[N];
    if (adv) begin
      q_r <= {{(W-N){q_fix[N-1]}}, q_fix[N-1:0]};
      r_r <= {{(W-N){r_fix[N-1]}}, r_fix[N-1:0]};
      st_r <= it_r[N].special ? it_r[N].sp_st : sfd_pkg::ST_OK;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(q_r) && $stable(st_r)))
    else $error("result changed while stalled");
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (st_r != 2'd3)) else $error("bad status");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && st_r != sfd_pkg::ST_OK) |-> (q_r == '0 && r_r == '0))
    else $error("error result not cleared");
endmodule
`default_nettype wire

[src/signed_floor_truncate_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Signed floor/truncate divider
// Top level: front end, decoupling queue and divide pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one division per transaction: dividend, divisor,
//   rounding mode (tuser bit 0: floor) and the remainder-only flag (tuser bit 1).
//   The output channel returns quotient and remainder in tdata and the status
//   (0 ok, 1 divide by zero, 2 overflow) in tuser.
//   Throughput is one transaction per cycle while the receiver is ready. An
//   accepted transaction passes the queue, the load stage, DATA_WIDTH
//   restoring-divide stages of one quotient bit each, and the output register.
//   A receiver stall freezes the whole divide pipeline; the two-entry queue
//   keeps accepting until it is full. Reset empties queue and pipeline.
// ----------------------------------------------------------------------------
module signed_floor_truncate_divider #(
  parameter int DATA_WIDTH = sfd_pkg::DATA_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,  // dividend[63:0], divisor[127:64]
  input  wire logic [1:0]   in_tuser,  // func[0], remainder_only[1]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata, // quotient[63:0], remainder[127:64]
  output logic [1:0]        out_tuser  // status[1:0]
);
  sfd_pkg::item_t f_item, q_item;
  logic q_valid, q_ready;

  sfd_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .dividend(in_tdata[63:0]), .divisor(in_tdata[127:64]),
    .func(in_tuser[0]), .remainder_only(in_tuser[1]), .item(f_item)
  );

  sfd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(in_tvalid), .wr_ready(in_tready),
    .wr_data(f_item), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_item)
  );

  sfd_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(q_valid), .in_ready(q_ready),
    .in_item(q_item), .out_valid(out_tvalid), .out_ready(out_tready),
    .q_o(out_tdata[63:0]), .r_o(out_tdata[127:64]), .st_o(out_tuser)
  );
endmodule
`default_nettype wire
